// ----- hw/rtl/ffba_pkg.sv -----
// Package with shared constants and types of the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;

  localparam int MAX_BLOCKS   = 1024;
  localparam int BLOCK_BYTES  = 16;
  localparam int HEADER_BYTES = 8;

  localparam int REQ_W   = 15;
  localparam int BLK_W   = 10;
  localparam int GRANT_W = 11;
  localparam int POOL_W  = 11;
  localparam int TOT_W   = 16;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_NOFIT = 1'b1;

  localparam int REG_POOL_BLOCKS = 0;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_A_WALK,
    ST_A_USE,
    ST_R_WALK,
    ST_R_NEXT,
    ST_R_GETR,
    ST_R_GETP,
    ST_R_DEC,
    ST_WR,
    ST_RESP
  } state_e;

endpackage

// ----- hw/rtl/first_fit_block_allocator_top.sv -----
// Top level of the first-fit block allocator with a free-list RAM and a sequencer.
// Allocate: the request is sized, each free region visited is read and checked,
// up to three list entries are written, then the result.
// Release: the regions before the block are visited, the block and the next free
// region are read, up to three list entries are written, then the result. One item at a time.
// After reset and after each pool_blocks write, a clearing sweep over all MAX_BLOCKS
// entries runs before the first item is accepted.
`timescale 1ns / 1ps
module first_fit_block_allocator_top #(
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS,
  parameter int BLOCK_BYTES  = ffba_pkg::BLOCK_BYTES,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // request_bytes[14:0], release_block[24:15], zeros above
  input  logic [31:0] s_axis_tdata,
  // command
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // start_block[9:0], granted_blocks[20:10], zeros above
  output logic [23:0] m_axis_tdata,
  // status
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW    = $clog2(MAX_BLOCKS);
  localparam int LW    = $clog2(MAX_BLOCKS + 1);
  localparam int WW    = 2 * LW;
  localparam int TOT_W = ffba_pkg::TOT_W;
  localparam int SH    = TOT_W + $clog2(BLOCK_BYTES);
  localparam logic [TOT_W:0] RECIP =
    (TOT_W + 1)'(((64'd1 << SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));
  localparam logic [LW-1:0] NIL = LW'(MAX_BLOCKS);
  localparam int POOL_RST = (MAX_BLOCKS < 1024) ? MAX_BLOCKS : 1024;

  ffba_pkg::state_e state_q, state_d;

  logic [ffba_pkg::POOL_W-1:0] pool_q;
  logic [LW-1:0]    head_q, head_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [ffba_pkg::BLK_W-1:0] rel_q, rel_d;
  logic [TOT_W-1:0] quo_q, quo_d;
  logic [LW-1:0]    cur_q, cur_d;
  logic [LW-1:0]    prev_q, prev_d;
  logic [LW-1:0]    steps_q, steps_d;
  logic [WW-1:0]    prevw_q, prevw_d;
  logic [WW-1:0]    rw_q, rw_d;
  logic [WW-1:0]    postw_q, postw_d;
  logic [LW-1:0]    pa_q [3];
  logic [LW-1:0]    pa_d [3];
  logic [WW-1:0]    pd_q [3];
  logic [WW-1:0]    pd_d [3];
  logic [1:0]       pn_q, pn_d;
  logic [1:0]       pi_q, pi_d;
  logic             res_st_q, res_st_d;
  logic [ffba_pkg::BLK_W-1:0]   res_blk_q, res_blk_d;
  logic [ffba_pkg::GRANT_W-1:0] res_gr_q, res_gr_d;

  logic             cfg_we;
  logic [ffba_pkg::POOL_W-1:0] cfg_val;
  logic             in_acc, out_acc;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [WW-1:0]    ram_wdata, ram_rdata;
  logic [2*TOT_W:0] prod;
  logic [TOT_W-1:0] num;
  logic [LW-1:0]    rd_len, rd_nxt;
  logic             walk_go;
  logic             rel_bad;

  function automatic logic [LW-1:0] norm_link(input logic [LW-1:0] x);
    return (32'(x) < MAX_BLOCKS) ? x : NIL;
  endfunction

  function automatic logic [LW-1:0] sat_len(input logic [31:0] x);
    return (x > 32'(MAX_BLOCKS)) ? NIL : LW'(x);
  endfunction

  assign pready = 1'b1;
  assign prdata = 32'(pool_q);
  assign cfg_we = psel && penable && pwrite;
  assign cfg_val = (pwdata[10:0] == 11'd0) ? 11'd1 :
                   (32'(pwdata[10:0]) > MAX_BLOCKS) ? ffba_pkg::POOL_W'(MAX_BLOCKS) :
                   pwdata[10:0];

  assign s_axis_tready = (state_q == ffba_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == ffba_pkg::ST_RESP);
  assign m_axis_tuser  = res_st_q;
  assign m_axis_tdata  = {3'd0, res_gr_q, res_blk_q};
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign prod   = (2 * TOT_W + 1)'(quo_q) * (2 * TOT_W + 1)'(RECIP);
  assign num    = quo_q;
  assign rd_len = ram_rdata[LW-1:0];
  assign rd_nxt = ram_rdata[WW-1:LW];
  assign walk_go = (cur_q != NIL) && (32'(cur_q) <= 32'(rel_q)) &&
                   (32'(steps_q) < MAX_BLOCKS);
  assign rel_bad = (32'(s_axis_tdata[24:15]) >= 32'(pool_q)) ||
                   (32'(s_axis_tdata[24:15]) >= MAX_BLOCKS);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ffba_pkg::ST_CLEAR: begin
        if (32'(clr_q) == MAX_BLOCKS - 1) state_d = ffba_pkg::ST_IDLE;
      end
      ffba_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == ffba_pkg::CMD_ALLOC) state_d = ffba_pkg::ST_DIV;
          else if (rel_bad) state_d = ffba_pkg::ST_RESP;
          else state_d = ffba_pkg::ST_R_WALK;
        end
      end
      ffba_pkg::ST_DIV: state_d = ffba_pkg::ST_A_WALK;
      ffba_pkg::ST_A_WALK: begin
        if (cur_q == NIL || 32'(steps_q) >= MAX_BLOCKS) state_d = ffba_pkg::ST_RESP;
        else state_d = ffba_pkg::ST_A_USE;
      end
      ffba_pkg::ST_A_USE: begin
        if (32'(rd_len) >= 32'(num)) state_d = ffba_pkg::ST_WR;
        else state_d = ffba_pkg::ST_A_WALK;
      end
      ffba_pkg::ST_R_WALK: begin
        if (walk_go) begin
          if (32'(cur_q) == 32'(rel_q)) state_d = ffba_pkg::ST_RESP;
          else state_d = ffba_pkg::ST_R_NEXT;
        end else begin
          state_d = ffba_pkg::ST_R_GETR;
        end
      end
      ffba_pkg::ST_R_NEXT: state_d = ffba_pkg::ST_R_WALK;
      ffba_pkg::ST_R_GETR: begin
        if (cur_q != NIL) state_d = ffba_pkg::ST_R_GETP;
        else state_d = ffba_pkg::ST_R_DEC;
      end
      ffba_pkg::ST_R_GETP: state_d = ffba_pkg::ST_R_DEC;
      ffba_pkg::ST_R_DEC:  state_d = ffba_pkg::ST_WR;
      ffba_pkg::ST_WR: begin
        if (pi_q >= pn_q) state_d = ffba_pkg::ST_RESP;
      end
      ffba_pkg::ST_RESP: begin
        if (out_acc) state_d = ffba_pkg::ST_IDLE;
      end
      default: state_d = ffba_pkg::ST_CLEAR;
    endcase
    if (cfg_we) state_d = ffba_pkg::ST_CLEAR;
  end

  always_comb begin
    logic [LW-1:0] after, tail_i, r_i, lp, lr, lpost, nprev, nr, npost;
    logic [31:0]   tail_w;
    logic          left, right;
    head_d    = head_q;
    clr_d     = clr_q;
    rel_d     = rel_q;
    quo_d     = quo_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    steps_d   = steps_q;
    prevw_d   = prevw_q;
    rw_d      = rw_q;
    postw_d   = postw_q;
    pa_d      = pa_q;
    pd_d      = pd_q;
    pn_d      = pn_q;
    pi_d      = pi_q;
    res_st_d  = res_st_q;
    res_blk_d = res_blk_q;
    res_gr_d  = res_gr_q;
    ram_we    = 1'b0;
    ram_waddr = clr_q;
    ram_wdata = '0;
    ram_raddr = AW'(cur_q);
    after  = norm_link(rd_nxt);
    tail_w = 32'(cur_q) + 32'(num);
    tail_i = LW'(tail_w);
    r_i    = LW'(rel_q);
    lp     = prevw_q[LW-1:0];
    nprev  = prevw_q[WW-1:LW];
    lr     = rw_q[LW-1:0];
    nr     = rw_q[WW-1:LW];
    lpost  = postw_q[LW-1:0];
    npost  = postw_q[WW-1:LW];
    left   = (prev_q != NIL) && (32'(prev_q) + 32'(lp) == 32'(r_i));
    right  = (cur_q != NIL) && (32'(r_i) + 32'(lr) == 32'(cur_q));

    case (state_q)
      ffba_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = (clr_q == '0) ? {NIL, LW'(pool_q)} : '0;
        clr_d     = clr_q + AW'(1);
      end
      ffba_pkg::ST_IDLE: begin
        if (in_acc) begin
          rel_d     = s_axis_tdata[24:15];
          quo_d     = TOT_W'(s_axis_tdata[14:0]) +
                      TOT_W'(HEADER_BYTES + BLOCK_BYTES - 1);
          cur_d     = norm_link(head_q);
          prev_d    = NIL;
          steps_d   = '0;
          pn_d      = '0;
          pi_d      = '0;
          res_st_d  = (s_axis_tuser == ffba_pkg::CMD_ALLOC) ? ffba_pkg::STATUS_NOFIT
                                                            : ffba_pkg::STATUS_DONE;
          res_blk_d = (s_axis_tuser == ffba_pkg::CMD_ALLOC) ? '0 : s_axis_tdata[24:15];
          res_gr_d  = '0;
        end
      end
      ffba_pkg::ST_DIV: begin
        quo_d = TOT_W'(prod >> SH);
      end
      ffba_pkg::ST_A_WALK: begin
        ram_raddr = AW'(cur_q);
      end
      ffba_pkg::ST_A_USE: begin
        if (32'(rd_len) >= 32'(num)) begin
          res_st_d  = ffba_pkg::STATUS_DONE;
          res_blk_d = ffba_pkg::BLK_W'(cur_q);
          res_gr_d  = ffba_pkg::GRANT_W'(num);
          if (32'(rd_len) == 32'(num) || tail_w >= 32'(MAX_BLOCKS)) begin
            if (prev_q == NIL) begin
              head_d = after;
            end else begin
              pa_d[0] = prev_q;
              pd_d[0] = {after, lp};
              pn_d    = 2'd1;
            end
          end else begin
            pa_d[0] = tail_i;
            pd_d[0] = {after, rd_len - LW'(num)};
            pa_d[1] = cur_q;
            pd_d[1] = {rd_nxt, LW'(num)};
            if (prev_q == NIL) begin
              head_d = tail_i;
              pn_d   = 2'd2;
            end else begin
              pa_d[2] = prev_q;
              pd_d[2] = {tail_i, lp};
              pn_d    = 2'd3;
            end
          end
        end else begin
          prev_d  = cur_q;
          prevw_d = ram_rdata;
          cur_d   = after;
          steps_d = steps_q + LW'(1);
        end
      end
      ffba_pkg::ST_R_WALK: begin
        ram_raddr = walk_go ? AW'(cur_q) : AW'(r_i);
      end
      ffba_pkg::ST_R_NEXT: begin
        prev_d  = cur_q;
        prevw_d = ram_rdata;
        cur_d   = after;
        steps_d = steps_q + LW'(1);
      end
      ffba_pkg::ST_R_GETR: begin
        rw_d      = ram_rdata;
        ram_raddr = AW'(cur_q);
      end
      ffba_pkg::ST_R_GETP: begin
        postw_d = ram_rdata;
      end
      ffba_pkg::ST_R_DEC: begin
        if (left && right) begin
          pa_d[0] = prev_q;
          pd_d[0] = {norm_link(npost), sat_len(32'(lp) + 32'(lr) + 32'(lpost))};
          pa_d[1] = r_i;
          pd_d[1] = {nr, LW'(0)};
          pa_d[2] = cur_q;
          pd_d[2] = {npost, LW'(0)};
          pn_d    = 2'd3;
        end else if (left) begin
          pa_d[0] = prev_q;
          pd_d[0] = {nprev, sat_len(32'(lp) + 32'(lr))};
          pa_d[1] = r_i;
          pd_d[1] = {nr, LW'(0)};
          pn_d    = 2'd2;
        end else if (right) begin
          pa_d[0] = r_i;
          pd_d[0] = {norm_link(npost), sat_len(32'(lr) + 32'(lpost))};
          pa_d[1] = cur_q;
          pd_d[1] = {npost, LW'(0)};
          if (prev_q == NIL) begin
            head_d = r_i;
            pn_d   = 2'd2;
          end else begin
            pa_d[2] = prev_q;
            pd_d[2] = {r_i, lp};
            pn_d    = 2'd3;
          end
        end else begin
          pa_d[0] = r_i;
          pd_d[0] = {cur_q, lr};
          if (prev_q == NIL) begin
            head_d = r_i;
            pn_d   = 2'd1;
          end else begin
            pa_d[1] = prev_q;
            pd_d[1] = {r_i, lp};
            pn_d    = 2'd2;
          end
        end
      end
      ffba_pkg::ST_WR: begin
        if (pi_q < pn_q) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(pa_q[pi_q]);
          ram_wdata = pd_q[pi_q];
          pi_d      = pi_q + 2'd1;
        end
      end
      default: begin
      end
    endcase

    if (cfg_we) begin
      clr_d  = '0;
      head_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffba_pkg::ST_CLEAR;
      pool_q  <= ffba_pkg::POOL_W'(POOL_RST);
      head_q  <= '0;
      clr_q   <= '0;
      pn_q    <= '0;
      pi_q    <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      clr_q   <= clr_d;
      pn_q    <= pn_d;
      pi_q    <= pi_d;
      if (cfg_we) pool_q <= cfg_val;
    end
  end

  always_ff @(posedge clk_i) begin
    rel_q     <= rel_d;
    quo_q     <= quo_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    steps_q   <= steps_d;
    prevw_q   <= prevw_d;
    rw_q      <= rw_d;
    postw_q   <= postw_d;
    pa_q      <= pa_d;
    pd_q      <= pd_d;
    res_st_q  <= res_st_d;
    res_blk_q <= res_blk_d;
    res_gr_q  <= res_gr_d;
  end

  ffba_ram #(
    .WIDTH(WW),
    .DEPTH(MAX_BLOCKS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  logic unused_paddr;
  assign unused_paddr = paddr[0] ^ paddr[1];

endmodule

// ----- hw/rtl/ffba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module ffba_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- hw/rtl/ffba_chk.sv -----
// Port-level checker of the first-fit block allocator and its bind statement.
`timescale 1ns / 1ps
module ffba_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("Result was withdrawn before its transfer.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input was ready again right after a transfer.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("Input was ready while a result was pending.");

  a_nofit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ffba_pkg::STATUS_NOFIT) |-> m_axis_tdata == '0)
    else $error("A failed allocate carried nonzero data.");

endmodule

bind first_fit_block_allocator_top ffba_chk u_ffba_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
